/* rtl/pql_pkg.sv */
`timescale 1ns / 1ps
package pql_pkg;

    // Table geometry
    localparam int REGIONS = 1024;
    localparam int ADDR_W  = $clog2(REGIONS);
    localparam int CNT_W   = $clog2(REGIONS + 1);

    // Field widths
    localparam int SLOT_W  = 10;
    localparam int POINT_W = 17;
    localparam int COEF_W  = 32;
    localparam int RC_W    = 11;

    localparam logic [RC_W-1:0] RC_RESET = 11'd1024;

    // Request actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic [POINT_W-1:0] region_start;
        logic [POINT_W-1:0] region_end;
    } bounds_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] constant;
    } coef_t;

    localparam int BOUNDS_W = $bits(bounds_t);
    localparam int COEFS_W  = $bits(coef_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_cmd_t;

    typedef struct packed {
        logic               start;
        logic [POINT_W-1:0] point;
        coef_t              coef;
    } eval_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [COEF_W-1:0] value;
    } eval_rsp_t;

endpackage

/* rtl/pql_req_if.sv */
`timescale 1ns / 1ps
interface pql_req_if;
    import pql_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [SLOT_W-1:0]        slot;
    logic [POINT_W-1:0]       region_start;
    logic [POINT_W-1:0]       region_end;
    logic signed [COEF_W-1:0] coef_square;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_constant;
    logic [POINT_W-1:0]       point;

    modport source (
        output valid, action, slot, region_start, region_end,
               coef_square, coef_linear, coef_constant, point,
        input  ready
    );

    modport sink (
        input  valid, action, slot, region_start, region_end,
               coef_square, coef_linear, coef_constant, point,
        output ready
    );
endinterface

/* rtl/pql_rsp_if.sv */
`timescale 1ns / 1ps
interface pql_rsp_if;
    import pql_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] value;
    logic                     in_range;

    modport source (
        output valid, value, in_range,
        input  ready
    );

    modport sink (
        input  valid, value, in_range,
        output ready
    );
endinterface

/* rtl/pql_cfg_if.sv */
`timescale 1ns / 1ps
interface pql_cfg_if;
    import pql_pkg::*;

    logic            valid;
    logic            ready;
    logic [RC_W-1:0] region_count;

    modport source (
        output valid, region_count,
        input  ready
    );

    modport sink (
        input  valid, region_count,
        output ready
    );
endinterface

/* rtl/piecewise_quadratic_lookup_core.sv */
// Channel  Role    Handshake      Payload
// req      sink    valid/ready    action, slot, region_start, region_end,
//                                 coef_square, coef_linear, coef_constant, point
// rsp      source  valid/ready    value, in_range
// cfg      sink    valid/ready    region_count (ready always high)
//
// A load request writes the table on its accept edge.
// An evaluate request first runs a binary search of P probes
// (at most log2(region_count) + 1, so 11 for a full table) that reads
// the bounds memory once per cycle, then the multiply-and-sum stages,
// then the result moves into the output register.
// Reset clears control state only; table contents stay undefined until loaded.
// A stalled result waits in the output register while the next request runs.
`timescale 1ns / 1ps
module piecewise_quadratic_lookup_core (
    input  logic       clk,
    input  logic       rst_n,
    pql_req_if.sink    req,
    pql_rsp_if.source  rsp,
    pql_cfg_if.sink    cfg
);
    import pql_pkg::*;

    mem_cmd_t  mem_cmd;
    bounds_t   bounds_wdata, bounds_rdata;
    coef_t     coef_wdata, coef_rdata;
    eval_req_t eval_req;
    eval_rsp_t eval_rsp;

    // Search sequencer, configuration and output register
    pql_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cfg          (cfg),
        .rsp          (rsp),
        .mem_cmd      (mem_cmd),
        .bounds_wdata (bounds_wdata),
        .coef_wdata   (coef_wdata),
        .bounds_rdata (bounds_rdata),
        .coef_rdata   (coef_rdata),
        .eval_req     (eval_req),
        .eval_rsp     (eval_rsp)
    );

    // Interval bounds table
    pql_ram #(
        .WIDTH (BOUNDS_W),
        .DEPTH (REGIONS)
    ) u_bounds_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (bounds_wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr),
        .rdata (bounds_rdata)
    );

    // Coefficient table, read alongside the bounds
    pql_ram #(
        .WIDTH (COEFS_W),
        .DEPTH (REGIONS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (coef_wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr),
        .rdata (coef_rdata)
    );

    // Polynomial datapath
    pql_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .eval_req (eval_req),
        .eval_rsp (eval_rsp)
    );
endmodule

/* rtl/pql_ram.sv */
`timescale 1ns / 1ps
module pql_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; hold data while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/pql_eval.sv */
`timescale 1ns / 1ps
module pql_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  pql_pkg::eval_req_t  eval_req,
    output pql_pkg::eval_rsp_t  eval_rsp
);
    import pql_pkg::*;

    localparam int PROD_W = COEF_W + POINT_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - 16;
    localparam int X2_W   = 2*POINT_W + 1 - 16;

    logic                      v1_reg, v2_reg, v3_reg;
    logic [X2_W-1:0]           x2_reg;
    logic signed [COEF_W-1:0]  a_reg;
    logic signed [COEF_W-1:0]  c_reg;
    logic signed [PROD_W-1:0]  bx_reg;
    logic signed [PROD_W-1:0]  ax2_reg;
    logic signed [PROD_W:0]    bxc_reg;
    logic signed [COEF_W-1:0]  value_reg;

    logic [2*POINT_W:0]        sq;
    logic signed [SUM_W-1:0]   acc;
    logic signed [SH_W-1:0]    sh;
    logic signed [COEF_W-1:0]  sat;

    // Square the point with rounding to Q.16
    assign sq = (2*POINT_W+1)'(eval_req.point) * (2*POINT_W+1)'(eval_req.point)
              + (2*POINT_W+1)'(32768);

    // Sum, round half up, shift back to Q.16 and clamp
    assign acc = SUM_W'(ax2_reg) + SUM_W'(bxc_reg) + SUM_W'(32768);
    assign sh  = acc[SUM_W-1:16];

    always_comb
    begin
        if (sh[SH_W-1:COEF_W-1] == '0 || sh[SH_W-1:COEF_W-1] == '1)
        begin
            sat = sh[COEF_W-1:0];
        end
        else if (sh[SH_W-1])
        begin
            sat = {1'b1, {(COEF_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(COEF_W-1){1'b1}}};
        end
    end

    // Advance the stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= eval_req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one: x squared, b times x, hold a and c
    always_ff @(posedge clk)
    begin
        if (eval_req.start)
        begin
            x2_reg <= sq[2*POINT_W:16];
            a_reg  <= eval_req.coef.square;
            c_reg  <= eval_req.coef.constant;
            bx_reg <= eval_req.coef.linear * $signed({1'b0, eval_req.point});
        end
    end

    // Stage two: a times x squared, add the shifted constant to b times x
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            ax2_reg <= a_reg * $signed({1'b0, x2_reg});
            bxc_reg <= (PROD_W+1)'(bx_reg) + (PROD_W+1)'($signed({c_reg, 16'h0000}));
        end
    end

    // Stage three: final sum and saturation
    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            value_reg <= sat;
        end
    end

    assign eval_rsp.done  = v3_reg;
    assign eval_rsp.value = value_reg;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        eval_req.start |=> ##2 eval_rsp.done)
        else $error("evaluation result not ready three cycles after start");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        eval_rsp.done |-> $past(eval_req.start, 3))
        else $error("evaluation result without a start");

    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({v1_reg, v2_reg, v3_reg}) <= 1)
        else $error("two evaluations in flight");
endmodule

/* rtl/pql_ctrl.sv */
`timescale 1ns / 1ps
module pql_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    pql_req_if.sink             req,
    pql_cfg_if.sink             cfg,
    pql_rsp_if.source           rsp,
    output pql_pkg::mem_cmd_t   mem_cmd,
    output pql_pkg::bounds_t    bounds_wdata,
    output pql_pkg::coef_t      coef_wdata,
    input  pql_pkg::bounds_t    bounds_rdata,
    input  pql_pkg::coef_t      coef_rdata,
    output pql_pkg::eval_req_t  eval_req,
    input  pql_pkg::eval_rsp_t  eval_rsp
);
    import pql_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_EVAL   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [RC_W-1:0]          rc_reg;
    logic [POINT_W-1:0]       x_reg, x_next;
    logic [CNT_W-1:0]         low_reg, low_next;
    logic [CNT_W-1:0]         high_reg, high_next;
    logic [ADDR_W-1:0]        cur_reg, cur_next;
    logic signed [COEF_W-1:0] res_value_reg, res_value_next;
    logic                     res_hit_reg, res_hit_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [COEF_W-1:0] out_value_reg, out_value_next;
    logic                     out_hit_reg, out_hit_next;

    logic                     req_fire;
    logic                     slot_ok;
    logic [CNT_W-1:0]         n_eff;
    logic                     hit;
    logic                     go_left;
    logic [CNT_W-1:0]         low_step, high_step;
    logic [CNT_W:0]           mid_sum;
    logic [ADDR_W-1:0]        probe;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.value    = out_value_reg;
    assign rsp.in_range = out_hit_reg;

    // Write data straight from the request
    assign bounds_wdata.region_start = req.region_start;
    assign bounds_wdata.region_end   = req.region_end;
    assign coef_wdata.square         = req.coef_square;
    assign coef_wdata.linear         = req.coef_linear;
    assign coef_wdata.constant       = req.coef_constant;

    assign slot_ok = (32'(req.slot) < REGIONS);
    assign n_eff   = (32'(rc_reg) > REGIONS) ? CNT_W'(REGIONS) : CNT_W'(rc_reg);

    // Probe compare and next midpoint
    assign hit       = (bounds_rdata.region_start <= x_reg)
                    && (bounds_rdata.region_end >= x_reg);
    assign go_left   = (bounds_rdata.region_start > x_reg);
    assign low_step  = go_left ? low_reg : CNT_W'(cur_reg);
    assign high_step = go_left ? CNT_W'(cur_reg) : high_reg;
    assign mid_sum   = (CNT_W+1)'(low_step) + (CNT_W+1)'(high_step);
    assign probe     = ADDR_W'(mid_sum[CNT_W:1]);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        cur_next       = cur_reg;
        res_value_next = res_value_reg;
        res_hit_next   = res_hit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_hit_next   = out_hit_reg;
        mem_cmd.we     = 1'b0;
        mem_cmd.waddr  = ADDR_W'(req.slot);
        mem_cmd.re     = 1'b0;
        mem_cmd.raddr  = cur_reg;
        eval_req.start = 1'b0;
        eval_req.point = x_reg;
        eval_req.coef  = coef_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.action == ACT_LOAD)
                    begin
                        mem_cmd.we = slot_ok;
                    end
                    else if (n_eff == '0)
                    begin
                        res_value_next = '0;
                        res_hit_next   = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        // Issue the first probe at the middle of the table
                        x_next        = req.point;
                        low_next      = '0;
                        high_next     = n_eff;
                        cur_next      = ADDR_W'(n_eff >> 1);
                        mem_cmd.re    = 1'b1;
                        mem_cmd.raddr = ADDR_W'(n_eff >> 1);
                        state_next    = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    eval_req.start = 1'b1;
                    state_next     = ST_EVAL;
                end
                else if (probe == cur_reg)
                begin
                    // Search stalled: point lies outside every interval
                    res_value_next = '0;
                    res_hit_next   = 1'b0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    low_next      = low_step;
                    high_next     = high_step;
                    cur_next      = probe;
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = probe;
                end
            end
            ST_EVAL:
            begin
                if (eval_rsp.done)
                begin
                    res_value_next = eval_rsp.value;
                    res_hit_next   = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand over to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_hit_next   = res_hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rc_reg        <= RC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                rc_reg <= cfg.region_count;
            end
        end
    end

    // Search and result payload
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        cur_reg       <= cur_next;
        res_value_reg <= res_value_next;
        res_hit_reg   <= res_hit_next;
        out_value_reg <= out_value_next;
        out_hit_reg   <= out_hit_next;
    end

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH)
        |-> (CNT_W'(cur_reg) >= low_reg) && (CNT_W'(cur_reg) < high_reg))
        else $error("probe outside the search window");

    a_start_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        eval_req.start |=> (state_reg == ST_EVAL))
        else $error("evaluation started without waiting for it");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented outside the hand-over step");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.we && mem_cmd.re))
        else $error("table written and read in the same cycle");
endmodule
